// File: rtl/gbss_pkg.sv
// Shared types and constants for the gap-based section splitter.
// No dependencies; imported by every module of the block.
package gbss_pkg;

    // Longest profile position and sample width
    localparam int MAX_LEN     = 65536;
    localparam int SAMPLE_BITS = 16;

    // Position counter width: holds 0 .. MAX_LEN
    localparam int POS_W = $clog2(MAX_LEN + 1);
    // Width of the section fields on the result stream
    localparam int OUT_W = 17;
    // Register field widths
    localparam int THR_W = 16;
    localparam int LEN_CFG_W = 17;
    // Width used for length comparisons
    localparam int LEN_W = (POS_W > LEN_CFG_W) ? POS_W : LEN_CFG_W;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_LENGTH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SECTION_LENGTH  = 2'd3;

    // Byte-mode full-scale code
    localparam logic [7:0] BYTE_FULL = 8'hFF;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic                 separator_mode;
        logic [THR_W-1:0]     separator_threshold;
        logic [LEN_CFG_W-1:0] min_gap_length;
        logic [LEN_CFG_W-1:0] min_section_length;
    } cfg_t;

    // Results caused by one sample: one or two sections
    typedef struct packed {
        logic two;
        pos_t start0;
        pos_t end0;
        pos_t start1;
        pos_t end1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/gbss_front.sv
// Front end: classifies each sample, tracks sections and gaps, and
// queues the sections that each sample closes. Uses gbss_pkg.
module gbss_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbss_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gbss_pkg::SAMPLE_BITS-1:0] s_tdata,  // [15:0] sample
    input  logic                          s_tlast,     // end_of_stream
    input  gbss_pkg::q_status_t           q_status,
    output logic                          push,
    output gbss_pkg::entry_t              push_entry
);
    import gbss_pkg::*;

    typedef enum logic [1:0] {PH_LEAD, PH_CONTENT, PH_GAP} phase_t;

    localparam pos_t POS_MAX = POS_W'(MAX_LEN);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = '1;

    phase_t phase_reg, phase_next;
    pos_t   position_reg, position_next;
    pos_t   section_left_reg, section_left_next;
    pos_t   gap_start_reg, gap_start_next;
    logic   saw_full_reg, saw_full_next;

    logic   accept;
    logic   sep, full;
    pos_t   pos_inc;
    logic   gap_closes;
    logic   emit_a, emit_b;
    pos_t   b_end;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // Separator / full-scale classification
    always_comb
    begin
        if (!cfg.separator_mode)
        begin
            sep  = (s_tdata[7:0] != 8'd0);
            full = (s_tdata[7:0] == BYTE_FULL);
        end
        else
        begin
            sep  = ({{(LEN_W > SAMPLE_BITS ? 1 : 1){1'b0}}, s_tdata} >=
                    {1'b0, SAMPLE_BITS'(cfg.separator_threshold)});
            full = (s_tdata == SAMPLE_FULL);
        end
    end

    // Saturating position increment
    assign pos_inc = (position_reg < POS_MAX) ? position_reg + pos_t'(1) : POS_MAX;

    assign gap_closes =
        (LEN_W'(position_reg - gap_start_reg) >= LEN_W'(cfg.min_gap_length)) || saw_full_reg;

    // Next state and the sections this sample closes
    always_comb
    begin
        phase_next        = phase_reg;
        section_left_next = section_left_reg;
        gap_start_next    = gap_start_reg;
        saw_full_next     = saw_full_reg;
        emit_a            = 1'b0;
        emit_b            = 1'b0;
        b_end             = gap_start_reg;

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (!sep)
                begin
                    section_left_next = position_reg;
                    phase_next        = PH_CONTENT;
                end
            end
            PH_CONTENT:
            begin
                if (sep)
                begin
                    gap_start_next = position_reg;
                    saw_full_next  = full;
                    phase_next     = PH_GAP;
                end
            end
            PH_GAP:
            begin
                if (sep)
                begin
                    saw_full_next = saw_full_reg || full;
                end
                else
                begin
                    if (gap_closes)
                    begin
                        emit_a = (LEN_W'(gap_start_reg - section_left_reg) >=
                                  LEN_W'(cfg.min_section_length));
                        section_left_next = position_reg;
                    end
                    saw_full_next = 1'b0;
                    phase_next    = PH_CONTENT;
                end
            end
            default:
            begin
                phase_next = PH_LEAD;
            end
        endcase

        // Stream end closes whatever is open
        if (s_tlast)
        begin
            if (phase_next == PH_CONTENT)
                b_end = pos_inc;
            else
                b_end = gap_start_next;
            emit_b = (phase_next != PH_LEAD) &&
                     (LEN_W'(b_end - section_left_next) >= LEN_W'(cfg.min_section_length));
        end
    end

    // Queue entry: first result in slot 0
    always_comb
    begin
        push_entry.two    = emit_a && emit_b;
        push_entry.start0 = emit_a ? section_left_reg : section_left_next;
        push_entry.end0   = emit_a ? gap_start_reg : b_end;
        push_entry.start1 = section_left_next;
        push_entry.end1   = b_end;
    end

    assign push = accept && (emit_a || emit_b);

    // Section-tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEAD;
            position_reg     <= '0;
            section_left_reg <= '0;
            gap_start_reg    <= '0;
            saw_full_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                phase_reg        <= PH_LEAD;
                position_reg     <= '0;
                section_left_reg <= '0;
                gap_start_reg    <= '0;
                saw_full_reg     <= 1'b0;
            end
            else
            begin
                phase_reg        <= phase_next;
                position_reg     <= position_next;
                section_left_reg <= section_left_next;
                gap_start_reg    <= gap_start_next;
                saw_full_reg     <= saw_full_next;
            end
        end
    end

    assign position_next = pos_inc;

endmodule

// File: rtl/gbss_queue.sv
// Short result queue in flip-flops between front and back.
// Uses gbss_pkg for the entry type and depth.
module gbss_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gbss_pkg::entry_t    push_entry,
    input  logic                pop,
    output gbss_pkg::entry_t    pop_entry,
    output gbss_pkg::q_status_t status
);
    import gbss_pkg::*;

    entry_t              store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = store_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

    overflow_a: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("queue pushed while full");

    underflow_a: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("queue popped while empty");

endmodule

// File: rtl/gbss_back.sv
// Back end: drains the queue and presents one section per transfer
// on the result stream through an output register. Uses gbss_pkg.
module gbss_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbss_pkg::q_status_t           q_status,
    input  gbss_pkg::entry_t              pop_entry,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*gbss_pkg::OUT_W+5:0]  m_tdata,  // [16:0] section_start, [33:17] section_end
    output logic                          m_tlast   // last_of_run
);
    import gbss_pkg::*;

    logic             valid_reg;
    logic             second_pending_reg;
    logic [OUT_W-1:0] start_reg, end_reg;
    logic             last_reg;
    pos_t             held_start_reg, held_end_reg;
    logic             load;

    assign load = !valid_reg || m_tready;
    assign pop  = load && !second_pending_reg && !q_status.empty;

    // Output valid and second-result tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= 1'b0;
            second_pending_reg <= 1'b0;
        end
        else if (load)
        begin
            if (second_pending_reg)
            begin
                valid_reg          <= 1'b1;
                second_pending_reg <= 1'b0;
            end
            else if (!q_status.empty)
            begin
                valid_reg          <= 1'b1;
                second_pending_reg <= pop_entry.two;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (second_pending_reg)
            begin
                start_reg <= OUT_W'(held_start_reg);
                end_reg   <= OUT_W'(held_end_reg);
                last_reg  <= 1'b1;
            end
            else if (!q_status.empty)
            begin
                start_reg      <= OUT_W'(pop_entry.start0);
                end_reg        <= OUT_W'(pop_entry.end0);
                last_reg       <= !pop_entry.two;
                held_start_reg <= pop_entry.start1;
                held_end_reg   <= pop_entry.end1;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, end_reg, start_reg};
    assign m_tlast  = last_reg;

    first_of_pair_a: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> second_pending_reg)
        else $error("first of two sections shown without the second held");

    pair_follows_a: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg && m_tready) |=> (valid_reg && last_reg))
        else $error("second section did not follow the first");

endmodule

// File: rtl/gap_based_section_splitter.sv
// Gap-based section splitter. Takes one profile sample per cycle while
// s_tready is high; each sample gives its results into a four-entry queue,
// which the result register drains at one section per cycle while m_tready
// is high. A sample that closes two sections occupies the result stream
// for two transfers, and s_tready drops only when the queue is full.
// Registers are written on the cfg channel, which is always ready.
module gap_based_section_splitter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gbss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbss_pkg::LEN_CFG_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gbss_pkg::SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
    input  logic                             s_tlast,   // end_of_stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [2*gbss_pkg::OUT_W+5:0]     m_tdata,   // [16:0] section_start, [33:17] section_end
    output logic                             m_tlast    // last_of_run
);
    import gbss_pkg::*;

    cfg_t      cfg_reg;
    q_status_t q_status;
    entry_t    push_entry, pop_entry;
    logic      push, pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator_mode      <= 1'b0;
            cfg_reg.separator_threshold <= THR_W'(1);
            cfg_reg.min_gap_length      <= LEN_CFG_W'(1);
            cfg_reg.min_section_length  <= LEN_CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEPARATOR_MODE:      cfg_reg.separator_mode      <= cfg_data[0];
                CFG_SEPARATOR_THRESHOLD: cfg_reg.separator_threshold <= cfg_data[THR_W-1:0];
                CFG_MIN_GAP_LENGTH:      cfg_reg.min_gap_length      <= cfg_data;
                CFG_MIN_SECTION_LENGTH:  cfg_reg.min_section_length  <= cfg_data;
                default:                 cfg_reg.separator_mode      <= cfg_reg.separator_mode;
            endcase
        end
    end

    gbss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    gbss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    gbss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for gap_based_section_splitter.
// Needs gbss_pkg and the splitter RTL; predicts sections per sample and
// checks every result transfer, under random idling on both streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbss_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASE_ITEMS   = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int DIRECTED_ROWS = 36;

    typedef enum logic [1:0] {PH_LEAD, PH_CONTENT, PH_GAP} profile_phase_e;
    typedef enum logic [1:0] {CLS_CONTENT, CLS_SEP, CLS_FULL} sample_cls_e;
    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_e;

    typedef struct packed {
        logic [OUT_W-1:0] sec_start;
        logic [OUT_W-1:0] sec_end;
        logic             run_last;
    } section_t;

    // a: sample or register index, b: end of stream or register data,
    // n_typed: number of sections typed in, -1 when left to the predictor
    typedef struct {
        row_kind_e kind;
        int        a;
        int        b;
        int        n_typed;
        int        s0, e0, s1, e1;
    } drow_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [LEN_CFG_W-1:0]     cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [SAMPLE_BITS-1:0]   s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [2*OUT_W+5:0]       m_tdata;
    logic                     m_tlast;

    gap_based_section_splitter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predictor state and register copy
    cfg_t           regs;
    pos_t           pos_now;
    profile_phase_e profile_phase;
    pos_t           sec_left;
    pos_t           gap_first;
    logic           gap_full;

    section_t pending_sections[$];
    int       failures = 0;
    int       cycles = 0;
    int       random_items = 0;
    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;
    int       rx_wait = 0;
    logic     hold_off = 1'b0;

    // Directed stimulus
    drow_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // reset settings: byte mode, gap 1, section 1
        '{ROW_SAMPLE, 'h0000, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'hFF00, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0005, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0000, 0,  1, 0, 2, 0, 0},
        '{ROW_SAMPLE, 'h0100, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h00FF, 0, -1, 0, 0, 0, 0},
        // content after a closing gap that also ends the profile: two sections
        '{ROW_SAMPLE, 'h0000, 1,  2, 3, 5, 6, 7},
        // profile of separators only
        '{ROW_SAMPLE, 'h00FF, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0001, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'hFFFF, 1,  0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0000, 1,  1, 0, 1, 0, 0},
        '{ROW_SAMPLE, 'h1200, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0001, 1,  1, 0, 1, 0, 0},
        // threshold mode; threshold data carries a bit above the field
        '{ROW_CONFIG, CFG_SEPARATOR_MODE,      1,        -1, 0, 0, 0, 0},
        '{ROW_CONFIG, CFG_SEPARATOR_THRESHOLD, 'h18000,  -1, 0, 0, 0, 0},
        '{ROW_CONFIG, CFG_MIN_GAP_LENGTH,      3,        -1, 0, 0, 0, 0},
        '{ROW_CONFIG, CFG_MIN_SECTION_LENGTH,  2,        -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h7FFF, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h8000, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0000, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h7000, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'hFFFF, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0001, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'hFFFE, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h8001, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h9000, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0000, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0000, 1, -1, 0, 0, 0, 0},
        // extremes: mode data masked to one bit, threshold 0 makes all separators
        '{ROW_CONFIG, CFG_SEPARATOR_MODE,      3,        -1, 0, 0, 0, 0},
        '{ROW_CONFIG, CFG_SEPARATOR_THRESHOLD, 0,        -1, 0, 0, 0, 0},
        '{ROW_CONFIG, CFG_MIN_GAP_LENGTH,      0,        -1, 0, 0, 0, 0},
        '{ROW_CONFIG, CFG_MIN_SECTION_LENGTH,  0,        -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'h0000, 1,  0, 0, 0, 0, 0},
        '{ROW_CONFIG, CFG_SEPARATOR_THRESHOLD, 'hFFFF,   -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'hFFFE, 0, -1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 'hFFFF, 1,  1, 0, 1, 0, 0}
    };

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic clear_profile();
        pos_now       = '0;
        profile_phase = PH_LEAD;
        sec_left      = '0;
        gap_first     = '0;
        gap_full      = 1'b0;
    endtask

    // Append one expected section to the scoreboard
    task automatic queue_expected(input section_t sec);
        pending_sections.insert(pending_sections.size(), sec);
    endtask

    function automatic bit long_enough(pos_t first, pos_t stop);
        return int'(stop) - int'(first) >= int'(regs.min_section_length);
    endfunction

    // Random sample of the wanted class under the current settings
    function automatic logic [SAMPLE_BITS-1:0] make_sample(sample_cls_e cls);
        logic [SAMPLE_BITS-1:0] r;
        r = SAMPLE_BITS'($urandom);
        if (!regs.separator_mode)
        begin
            case (cls)
                CLS_CONTENT: r[7:0] = 8'h00;
                CLS_SEP:     r[7:0] = 8'($urandom_range(1, 254));
                default:     r[7:0] = BYTE_FULL;
            endcase
        end
        else
        begin
            case (cls)
                CLS_CONTENT:
                    if (regs.separator_threshold != 0)
                        r = SAMPLE_BITS'($urandom_range(0, regs.separator_threshold - 1));
                CLS_SEP:
                    if (regs.separator_threshold != 16'hFFFF)
                        r = SAMPLE_BITS'($urandom_range(regs.separator_threshold, 16'hFFFE));
                    else
                        r = '1;
                default: r = '1;
            endcase
        end
        return r;
    endfunction

    // Sections closed by one sample; queued as expected when log_it is set
    task automatic predict_sample(input logic [SAMPLE_BITS-1:0] smp, input logic eos,
                                  input bit log_it);
        logic     sep;
        logic     full;
        pos_t     p;
        pos_t     n;
        section_t found [2];
        int       cnt;
        cnt = 0;
        if (!regs.separator_mode)
        begin
            sep  = smp[7:0] != 8'h00;
            full = smp[7:0] == BYTE_FULL;
        end
        else
        begin
            sep  = smp >= regs.separator_threshold;
            full = smp == {SAMPLE_BITS{1'b1}};
        end
        full = full && sep;
        p = pos_now;
        n = (p < MAX_LEN) ? p + 1'b1 : pos_t'(MAX_LEN);

        case (profile_phase)
            PH_LEAD:
                if (!sep)
                begin
                    sec_left      = p;
                    profile_phase = PH_CONTENT;
                end
            PH_CONTENT:
                if (sep)
                begin
                    gap_first     = p;
                    gap_full      = full;
                    profile_phase = PH_GAP;
                end
            default:
                if (sep)
                    gap_full = gap_full || full;
                else
                begin
                    // a long enough gap, or one with a full-scale sample, closes
                    if (int'(p) - int'(gap_first) >= int'(regs.min_gap_length) || gap_full)
                    begin
                        if (long_enough(sec_left, gap_first))
                        begin
                            found[cnt] = '{sec_left, gap_first, 1'b0};
                            cnt++;
                        end
                        sec_left = p;
                    end
                    gap_full      = 1'b0;
                    profile_phase = PH_CONTENT;
                end
        endcase

        if (eos)
        begin
            if (profile_phase == PH_CONTENT && long_enough(sec_left, n))
            begin
                found[cnt] = '{sec_left, n, 1'b0};
                cnt++;
            end
            else if (profile_phase == PH_GAP && long_enough(sec_left, gap_first))
            begin
                found[cnt] = '{sec_left, gap_first, 1'b0};
                cnt++;
            end
            clear_profile();
        end
        else
            pos_now = n;

        for (int i = 0; i < cnt; i++)
        begin
            found[i].run_last = (i == cnt - 1);
            if (log_it)
                queue_expected(found[i]);
        end
    endtask

    // One sample transfer, after a random gap
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic eos,
                               input bit log_it);
        int gap;
        int pick;
        if ($urandom_range(0, 49) == 0)
            tx_calm = !tx_calm;
        pick = $urandom_range(0, 99);
        if (tx_calm || pick < 60)
            gap = 0;
        else if (pick < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_sample(smp, eos, log_it);
    endtask

    // Wait until the block is idle before a register write or the verdict
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_sections.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= value[LEN_CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx[CFG_IDX_W-1:0])
            CFG_SEPARATOR_MODE:      regs.separator_mode      = value[0];
            CFG_SEPARATOR_THRESHOLD: regs.separator_threshold = value[THR_W-1:0];
            CFG_MIN_GAP_LENGTH:      regs.min_gap_length      = value[LEN_CFG_W-1:0];
            CFG_MIN_SECTION_LENGTH:  regs.min_section_length  = value[LEN_CFG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Result side ready: short and long stalls, calm stretches, one hold-off
    always @(posedge clk)
    begin : drive_result_ready
        int r;
        if ($urandom_range(0, 299) == 0)
            rx_calm = !rx_calm;
        if (hold_off)
            m_tready <= 1'b0;
        else if (rx_wait > 0)
        begin
            rx_wait  = rx_wait - 1;
            m_tready <= 1'b0;
        end
        else if (rx_calm)
            m_tready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                rx_wait  = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    // Long hold-off so that the result queue fills and input stalls
    initial
    begin
        wait (random_items >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Section checker
    always @(posedge clk)
    begin : check_sections
        section_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sections.size() == 0)
            begin
                $error("unexpected section start=%0d end=%0d last=%0b",
                       m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W], m_tlast);
                failures++;
            end
            else
            begin
                want = pending_sections.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.sec_start)
                begin
                    $error("section_start: expected %0d, got %0d",
                           want.sec_start, m_tdata[OUT_W-1:0]);
                    failures++;
                end
                if (m_tdata[2*OUT_W-1:OUT_W] !== want.sec_end)
                begin
                    $error("section_end: expected %0d, got %0d",
                           want.sec_end, m_tdata[2*OUT_W-1:OUT_W]);
                    failures++;
                end
                if (m_tlast !== want.run_last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.run_last, m_tlast);
                    failures++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        drow_t                  row;
        logic [SAMPLE_BITS-1:0] row_samples[$];
        int                     k;
        int                     len;
        int                     run;
        int                     phase_end;
        int                     thr;
        int                     gap_len;
        int                     sec_len;
        bit                     noisy;

        regs.separator_mode      = 1'b0;
        regs.separator_threshold = 1;
        regs.min_gap_length      = 1;
        regs.min_section_length  = 1;
        clear_profile();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = directed_rows[k];
            if (row.kind == ROW_CONFIG)
            begin
                settle();
                write_reg(row.a, row.b);
            end
            else
            begin
                send_sample(SAMPLE_BITS'(row.a), row.b[0], row.n_typed < 0);
                if (row.n_typed >= 1)
                    queue_expected('{OUT_W'(row.s0), OUT_W'(row.e0), row.n_typed == 1});
                if (row.n_typed == 2)
                    queue_expected('{OUT_W'(row.s1), OUT_W'(row.e1), 1'b1});
            end
        end

        // Random phases, each under fresh settings
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 4))
                0:       thr = 0;
                1:       thr = 'hFFFF;
                default: thr = $urandom_range(1, 'hFFFE);
            endcase
            case ($urandom_range(0, 9))
                0:       gap_len = 0;
                1:       gap_len = MAX_LEN;
                2:       gap_len = 'h1FFFF;
                default: gap_len = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       sec_len = 0;
                1:       sec_len = MAX_LEN;
                2:       sec_len = 'h1FFFF;
                default: sec_len = $urandom_range(1, 5);
            endcase
            write_reg(CFG_SEPARATOR_MODE, $urandom_range(0, 1));
            write_reg(CFG_SEPARATOR_THRESHOLD, thr);
            write_reg(CFG_MIN_GAP_LENGTH, gap_len);
            write_reg(CFG_MIN_SECTION_LENGTH, sec_len);

            phase_end = random_items + PHASE_ITEMS;
            while (random_items < phase_end && random_items < RANDOM_ITEMS)
            begin
                // well-formed profile: leading separators, content and gap runs
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 30);
                noisy = $urandom_range(0, 99) < 15;
                row_samples.delete();
                run = $urandom_range(0, 3);
                repeat (run)
                    row_samples.insert(row_samples.size(), make_sample(CLS_SEP));
                while (row_samples.size() < len)
                begin
                    run = $urandom_range(1, 8);
                    repeat (run)
                        row_samples.insert(row_samples.size(), make_sample(CLS_CONTENT));
                    run = (regs.min_gap_length <= 12) ?
                          $urandom_range(1, regs.min_gap_length + 2) : $urandom_range(1, 4);
                    repeat (run)
                        row_samples.insert(row_samples.size(),
                                           make_sample(($urandom_range(0, 9) == 0) ?
                                                       CLS_FULL : CLS_SEP));
                end
                for (k = 0; k < len; k++)
                begin
                    send_sample(noisy ? SAMPLE_BITS'($urandom) : row_samples[k],
                                k == len - 1, 1'b1);
                    random_items++;
                end
            end
        end

        // Drain and verdict
        settle();
        if (failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
